// File: src/servo_pulse_slew_limiter_unit_defines.svh
// Assertion macros shared by the servo pulse slew limiter RTL.
`ifndef SERVO_PULSE_SLEW_LIMITER_UNIT_DEFINES_SVH
`define SERVO_PULSE_SLEW_LIMITER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPSL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spsl: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SPSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spsl: next-cycle check failed");

`endif

// File: src/spsl_pkg.sv
// Shared types, codes and constants of the servo pulse slew limiter.
`default_nettype none
package spsl_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int PULSE_W = 15;
  localparam int REQ_W = 16;
  localparam int DEADBAND_W = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [1:0] CMD_SET_TARGET = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_CENTER = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_STEER_MIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_MAX = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AUX_MIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AUX_MAX = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEW_STEP = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER = 3'd6;

  localparam logic [PULSE_W-1:0] RESET_MIN_PULSE = 15'd1000;
  localparam logic [PULSE_W-1:0] RESET_MAX_PULSE = 15'd2000;
  localparam logic [DEADBAND_W-1:0] RESET_DEADBAND = 10'd4;
  localparam logic [PULSE_W-1:0] RESET_SLEW_STEP = 15'd10;
  localparam logic [PULSE_W-1:0] RESET_CENTER = 15'd1500;

  typedef struct packed {
    logic [PULSE_W-1:0]    steer_min;
    logic [PULSE_W-1:0]    steer_max;
    logic [PULSE_W-1:0]    aux_min;
    logic [PULSE_W-1:0]    aux_max;
    logic [DEADBAND_W-1:0] deadband;
    logic [PULSE_W-1:0]    slew_step;
    logic [PULSE_W-1:0]    center;
  } cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] target;
    logic [PULSE_W-1:0] current;
  } entry_t;

endpackage
`default_nettype wire

// File: src/spsl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module spsl_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/spsl_cfg_regs.sv
// Configuration register file of the servo pulse slew limiter.
`default_nettype none
module spsl_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [spsl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [spsl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output spsl_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_min <= spsl_pkg::RESET_MIN_PULSE;
      cfg.steer_max <= spsl_pkg::RESET_MAX_PULSE;
      cfg.aux_min   <= spsl_pkg::RESET_MIN_PULSE;
      cfg.aux_max   <= spsl_pkg::RESET_MAX_PULSE;
      cfg.deadband  <= spsl_pkg::RESET_DEADBAND;
      cfg.slew_step <= spsl_pkg::RESET_SLEW_STEP;
      cfg.center    <= spsl_pkg::RESET_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spsl_pkg::REG_STEER_MIN: cfg.steer_min <= cfg_data;
        spsl_pkg::REG_STEER_MAX: cfg.steer_max <= cfg_data;
        spsl_pkg::REG_AUX_MIN:   cfg.aux_min <= cfg_data;
        spsl_pkg::REG_AUX_MAX:   cfg.aux_max <= cfg_data;
        spsl_pkg::REG_DEADBAND:  cfg.deadband <= cfg_data[spsl_pkg::DEADBAND_W-1:0];
        spsl_pkg::REG_SLEW_STEP: cfg.slew_step <= cfg_data;
        spsl_pkg::REG_CENTER:    cfg.center <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/servo_pulse_slew_limiter_unit.sv
// Servo pulse slew limiter: a sequencer around one state RAM holding each channel's widths.
//
// Input channel (in_valid/in_ready) carries cmd, servo_index and requested_pulse.
// A set-target transfer reads the channel's entry and writes it back in the next cycle,
// in ST_SET_WB, and gives no result.
// A tick reads and writes back each channel in turn, holding while the output stalls, and
// emits one result per channel in channel order; the last carries last_of_run.
// A center writes each channel in turn without a read and emits its result.
// Tick and center results are loaded into the output register from ST_TICK_WB or ST_CENTER.
// The rate is set by the state RAM's single port pair: every tick or set-target update
// is a read, then a write-back; a center only writes; in_ready is high only between items.
// Results sit in an output register (out_valid/out_ready); a finished result waits there
// and the next item is taken meanwhile. If the receiver stalls, the sequencer holds in its
// write-back step until the register frees, with read data kept in the RAM output.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register per cycle.
// Reset clears the registers to their defaults and marks every RAM entry as unwritten;
// an unwritten entry reads as 1500 for both widths, so no clearing pass is needed.
`default_nettype none
`include "servo_pulse_slew_limiter_unit_defines.svh"
module servo_pulse_slew_limiter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [spsl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [spsl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          cmd,
  input  wire logic [1:0]                          servo_index,
  input  wire logic [spsl_pkg::REQ_W-1:0]          requested_pulse,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_channel,
  output logic      [spsl_pkg::PULSE_W-1:0]        pulse_level,
  output logic                                     last_of_run
);

  localparam int CH_W = spsl_pkg::CH_W;
  localparam int PW = spsl_pkg::PULSE_W;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(spsl_pkg::CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WB,
    ST_TICK_RD,
    ST_TICK_WB,
    ST_CENTER
  } state_t;

  state_t state;
  logic [CH_W-1:0] ch_cnt;
  logic [CH_W-1:0] idx_q;
  logic [spsl_pkg::REQ_W-1:0] req_q;
  logic [spsl_pkg::CHANNELS-1:0] entry_valid;
  logic rd_valid;

  spsl_pkg::cfg_t cfg;
  spsl_pkg::entry_t ram_wdata;
  spsl_pkg::entry_t ram_rdata;
  spsl_pkg::entry_t rd_entry;
  logic ram_we;
  logic ram_re;
  logic [CH_W-1:0] ram_waddr;
  logic [CH_W-1:0] ram_raddr;

  logic accept;
  logic idx_ok;
  logic out_free;
  logic out_load;
  logic last_ch;

  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic [spsl_pkg::REQ_W-1:0] req_lo;
  logic [PW-1:0] clamped;
  logic [PW-1:0] delta;
  logic [PW-1:0] set_target;
  logic up;
  logic [PW-1:0] span;
  logic [PW-1:0] span_lim;
  logic [PW-1:0] tick_current;
  logic [PW-1:0] out_level;

  spsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spsl_ram #(
    .WIDTH ($bits(spsl_pkg::entry_t)),
    .DEPTH (spsl_pkg::CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign idx_ok = 32'(servo_index) < 32'(spsl_pkg::CHANNELS);
  assign out_free = !out_valid || out_ready;
  assign last_ch = (ch_cnt == LAST_CH);

  assign rd_entry = rd_valid ? ram_rdata
                             : spsl_pkg::entry_t'{target: spsl_pkg::RESET_CENTER,
                                                  current: spsl_pkg::RESET_CENTER};

  assign lo = (idx_q == CH_W'(0)) ? cfg.steer_min : cfg.aux_min;
  assign hi = (idx_q == CH_W'(0)) ? cfg.steer_max : cfg.aux_max;
  assign req_lo = (req_q < {1'b0, lo}) ? {1'b0, lo} : req_q;
  assign clamped = (req_lo > {1'b0, hi}) ? hi : req_lo[PW-1:0];
  assign delta = (clamped >= rd_entry.target) ? clamped - rd_entry.target
                                              : rd_entry.target - clamped;
  assign set_target = (delta >= PW'(cfg.deadband)) ? clamped : rd_entry.target;

  assign up = rd_entry.target > rd_entry.current;
  assign span = up ? rd_entry.target - rd_entry.current : rd_entry.current - rd_entry.target;
  assign span_lim = (span > cfg.slew_step) ? cfg.slew_step : span;
  assign tick_current = up ? rd_entry.current + span_lim : rd_entry.current - span_lim;

  always_comb begin
    ram_re = 1'b0;
    ram_raddr = ch_cnt;
    ram_we = 1'b0;
    ram_waddr = ch_cnt;
    ram_wdata = rd_entry;
    out_load = 1'b0;
    out_level = tick_current;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == spsl_pkg::CMD_SET_TARGET && idx_ok) begin
          ram_re = 1'b1;
          ram_raddr = servo_index[CH_W-1:0];
        end else if (accept && cmd == spsl_pkg::CMD_TICK) begin
          ram_re = 1'b1;
          ram_raddr = '0;
        end
      end
      ST_SET_WB: begin
        ram_we = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = '{target: set_target, current: rd_entry.current};
      end
      ST_TICK_RD: begin
        ram_re = 1'b1;
      end
      ST_TICK_WB: begin
        ram_we = out_free;
        ram_wdata = '{target: rd_entry.target, current: tick_current};
        out_load = out_free;
      end
      ST_CENTER: begin
        ram_we = out_free;
        ram_wdata = '{target: cfg.center, current: cfg.center};
        out_load = out_free;
        out_level = cfg.center;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch_cnt <= '0;
      entry_valid <= '0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_valid <= entry_valid[ram_raddr];
      end
      if (ram_we) begin
        entry_valid[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_channel <= ch_cnt[0];
        pulse_level <= out_level;
        last_of_run <= last_ch;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          ch_cnt <= '0;
          idx_q <= servo_index[CH_W-1:0];
          req_q <= requested_pulse;
          if (accept) begin
            if (cmd == spsl_pkg::CMD_SET_TARGET && idx_ok) begin
              state <= ST_SET_WB;
            end else if (cmd == spsl_pkg::CMD_TICK) begin
              state <= ST_TICK_WB;
            end else if (cmd == spsl_pkg::CMD_CENTER) begin
              state <= ST_CENTER;
            end
          end
        end
        ST_SET_WB: begin
          state <= ST_IDLE;
        end
        ST_TICK_RD: begin
          state <= ST_TICK_WB;
        end
        ST_TICK_WB: begin
          if (out_free) begin
            if (last_ch) begin
              state <= ST_IDLE;
            end else begin
              ch_cnt <= ch_cnt + CH_W'(1);
              state <= ST_TICK_RD;
            end
          end
        end
        ST_CENTER: begin
          if (out_free) begin
            if (last_ch) begin
              state <= ST_IDLE;
            end else begin
              ch_cnt <= ch_cnt + CH_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SPSL_ASSERT_SAME(a_no_rw_overlap, clk, rst, ram_we, !ram_re)
  `SPSL_ASSERT_SAME(a_load_when_free, clk, rst, out_load, (!out_valid || out_ready))
  `SPSL_ASSERT_SAME(a_last_is_top_channel, clk, rst, (out_valid && last_of_run),
    (out_channel == LAST_CH[0]))
  `SPSL_ASSERT_NEXT(a_tick_starts_wb, clk, rst, (accept && cmd == spsl_pkg::CMD_TICK),
    (state == ST_TICK_WB && ch_cnt == CH_W'(0)))

endmodule
`default_nettype wire
